[rtl/amrd_pkg.sv]
package amrd_pkg;

   localparam int unsigned FRAME_BYTES = 10;
   localparam int unsigned POS_W = 4;

   localparam logic [7:0] HDR_BYTE = 8'h7E;
   localparam logic [7:0] VER_BYTE = 8'hFF;
   localparam logic [7:0] LEN_BYTE = 8'h06;
   localparam logic [7:0] END_BYTE = 8'hEF;
   localparam logic [7:0] ACK_CMD = 8'h41;

   // Byte positions inside a reply frame.
   localparam logic [POS_W-1:0] POS_HUNT = 4'd0;
   localparam logic [POS_W-1:0] POS_VER = 4'd1;
   localparam logic [POS_W-1:0] POS_LEN = 4'd2;
   localparam logic [POS_W-1:0] POS_CMD = 4'd3;
   localparam logic [POS_W-1:0] POS_PAR_HI = 4'd5;
   localparam logic [POS_W-1:0] POS_PAR_LO = 4'd6;
   localparam logic [POS_W-1:0] POS_SUM_HI = 4'd7;
   localparam logic [POS_W-1:0] POS_SUM_LO = 4'd8;
   localparam logic [POS_W-1:0] POS_END = POS_W'(FRAME_BYTES - 1);

   typedef enum logic [2:0] {
      ST_ACK      = 3'd0,
      ST_FEEDBACK = 3'd1,
      ST_UNKNOWN  = 3'd2,
      ST_BAD_VER  = 3'd3,
      ST_BAD_LEN  = 3'd4,
      ST_BAD_END  = 3'd5,
      ST_BAD_SUM  = 3'd6
   } status_type;

   typedef struct packed {
      status_type  frame_status;
      logic [7:0]  reply_command;
      logic [15:0] reply_parameter;
      logic        awaiting_ack;
      logic        data_available;
   } result_type;

   function automatic logic is_feedback(input logic [7:0] c);
      is_feedback = ((c >= 8'h3A) && (c <= 8'h40)) ||
                    ((c >= 8'h42) && (c <= 8'h49)) ||
                    ((c >= 8'h4B) && (c <= 8'h4F));
   endfunction

endpackage

[rtl/audio_module_reply_deframer.sv]
// The result of an item that finishes a frame passes from the input register to the
// result register, where it waits with rsp_tvalid high until rsp_tready takes it.
// Throughput: one item per cycle while rsp_tready is high. While a result waits on
// rsp_tready the input register takes one more item and then holds req_tready low.
// Reset is synchronous and active high; it empties both registers and returns the
// parser to hunting for a header with all flags cleared.
module audio_module_reply_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] reply_command, [23:8] reply_parameter,
                                    // [24] awaiting_ack, [25] data_available, [31:26] zero
   output logic [2:0]  rsp_tuser    // [2:0] frame_status
);

   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   amrd_pkg::result_type out_ff;
   amrd_pkg::result_type result;
   logic        advance;
   logic        emit;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   amrd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .command (in_cmd_ff),
      .rx_byte (in_byte_ff),
      .emit    (emit),
      .result  (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_ff.frame_status;
   assign rsp_tdata = {6'd0, out_ff.data_available, out_ff.awaiting_ack,
                       out_ff.reply_parameter, out_ff.reply_command};

endmodule

[rtl/amrd_parser.sv]
module amrd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   command,
   input  logic [7:0]             rx_byte,
   output logic                   emit,
   output amrd_pkg::result_type   result
);

   logic [amrd_pkg::POS_W-1:0] pos_ff, pos_in, pos;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] par_ff, par_in;
   logic [15:0] chk_ff, chk_in;
   logic        ack_ff, ack_in;
   logic        ready_ff, ready_in;
   logic        rejected;
   logic [15:0] expect_sum;

   assign expect_sum = 16'd0 - sum_ff;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      cmd_in = cmd_ff;
      par_in = par_ff;
      chk_in = chk_ff;
      ack_in = ack_ff;
      ready_in = ready_ff;
      emit = 1'b0;
      rejected = 1'b0;
      result.frame_status = amrd_pkg::ST_ACK;
      result.reply_command = cmd_ff;
      result.reply_parameter = par_ff;
      pos = (pos_ff >= amrd_pkg::POS_W'(amrd_pkg::FRAME_BYTES)) ? amrd_pkg::POS_HUNT : pos_ff;

      if (command) begin
         ack_in = 1'b1;
      end else if (pos == amrd_pkg::POS_HUNT) begin
         if (rx_byte == amrd_pkg::HDR_BYTE) begin
            sum_in = 16'd0;
            pos_in = amrd_pkg::POS_VER;
         end else begin
            pos_in = amrd_pkg::POS_HUNT;
         end
      end else if (pos == amrd_pkg::POS_END) begin
         pos_in = amrd_pkg::POS_HUNT;
         emit = 1'b1;
         if (rx_byte != amrd_pkg::END_BYTE) begin
            result.frame_status = amrd_pkg::ST_BAD_END;
            ack_in = 1'b0;
         end else if (expect_sum != chk_ff) begin
            result.frame_status = amrd_pkg::ST_BAD_SUM;
            ack_in = 1'b0;
         end else if (cmd_ff == amrd_pkg::ACK_CMD) begin
            result.frame_status = amrd_pkg::ST_ACK;
            ack_in = 1'b0;
         end else if (amrd_pkg::is_feedback(cmd_ff)) begin
            result.frame_status = amrd_pkg::ST_FEEDBACK;
            ready_in = 1'b1;
         end else begin
            result.frame_status = amrd_pkg::ST_UNKNOWN;
            ack_in = 1'b0;
         end
      end else begin
         case (pos)
            amrd_pkg::POS_VER: begin
               if (rx_byte != amrd_pkg::VER_BYTE) begin
                  rejected = 1'b1;
                  result.frame_status = amrd_pkg::ST_BAD_VER;
               end
            end
            amrd_pkg::POS_LEN: begin
               if (rx_byte != amrd_pkg::LEN_BYTE) begin
                  rejected = 1'b1;
                  result.frame_status = amrd_pkg::ST_BAD_LEN;
               end
            end
            amrd_pkg::POS_CMD:    cmd_in = rx_byte;
            amrd_pkg::POS_PAR_HI: par_in = {rx_byte, par_ff[7:0]};
            amrd_pkg::POS_PAR_LO: par_in = {par_ff[15:8], rx_byte};
            amrd_pkg::POS_SUM_HI: chk_in = {rx_byte, chk_ff[7:0]};
            amrd_pkg::POS_SUM_LO: chk_in = {chk_ff[15:8], rx_byte};
            default: ;
         endcase
         if (rejected) begin
            // Early rejections report an empty command and parameter.
            emit = 1'b1;
            ack_in = 1'b0;
            pos_in = amrd_pkg::POS_HUNT;
            result.reply_command = 8'd0;
            result.reply_parameter = 16'd0;
         end else begin
            if (pos <= amrd_pkg::POS_PAR_LO) begin
               sum_in = sum_ff + {8'd0, rx_byte};
            end
            pos_in = pos + 1'b1;
         end
      end
      result.awaiting_ack = ack_in;
      result.data_available = ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= amrd_pkg::POS_HUNT;
         sum_ff <= 16'd0;
         cmd_ff <= 8'd0;
         par_ff <= 16'd0;
         chk_ff <= 16'd0;
         ack_ff <= 1'b0;
         ready_ff <= 1'b0;
      end else if (step) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         cmd_ff <= cmd_in;
         par_ff <= par_in;
         chk_ff <= chk_in;
         ack_ff <= ack_in;
         ready_ff <= ready_in;
      end
   end

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < amrd_pkg::POS_W'(amrd_pkg::FRAME_BYTES))
      else $error("byte position out of range");

   a_ack_request: assert property (@(posedge clock) disable iff (reset)
      step && command |=> ack_ff)
      else $error("ack request did not set the pending flag");

   a_emit_hunts: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> pos_ff == amrd_pkg::POS_HUNT)
      else $error("finished frame did not return to hunting");

   a_feedback_ready: assert property (@(posedge clock) disable iff (reset)
      step && emit && result.frame_status == amrd_pkg::ST_FEEDBACK |=> ready_ff)
      else $error("feedback frame did not set data available");

endmodule
